>>> rtl/core/battery_level_and_charge_monitor_unit_defines.svh
// Assertion helpers shared by the monitor's RTL files.
`ifndef BATTERY_LEVEL_AND_CHARGE_MONITOR_UNIT_DEFINES_SVH
`define BATTERY_LEVEL_AND_CHARGE_MONITOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BMON_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bmon: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define BMON_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bmon: next-cycle check failed");

`endif

>>> rtl/core/bmon_pkg.sv
package bmon_pkg;

  localparam int unsigned SAMPLE_W      = 10;
  localparam int unsigned SAMPLE_FIELDS = 5;
  localparam int unsigned PERCENT_W     = 7;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned LEVEL_RAW_W   = 9;

  // Reciprocal multiply shift used for every division by a constant.
  localparam int unsigned DIV_SHIFT = 24;
  localparam int unsigned RECIP_W   = DIV_SHIFT + 1;

  localparam int unsigned JUDGE_COUNT   = 5;
  localparam int unsigned PLUG_MIN_RISE = 3;

  localparam int unsigned LEVEL_NUM     = 34;
  localparam int unsigned LEVEL_DEN     = 100;
  localparam int unsigned LEVEL_CAP_AT  = 88;
  localparam int unsigned LEVEL_FULL    = 100;
  localparam int unsigned LEVEL_LOW_MAX = 20;
  localparam int unsigned LEVEL_MIN     = 1;
  localparam int unsigned LEVEL_RESET   = 50;

  localparam int unsigned BASE_W        = 10;
  localparam int unsigned SLOW_IV_W     = 16;
  localparam int unsigned LEVEL_IV_W    = 8;
  localparam int unsigned BASE_RESET    = 550;
  localparam int unsigned SLOW_IV_RESET = 1000;
  localparam int unsigned LEVEL_IV_RESET = 60;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned BATCH_SIZE_DEF    = 5;
  localparam int unsigned FAST_DEPTH_DEF    = 5;
  localparam int unsigned SLOW_DEPTH_DEF    = 20;
  localparam int unsigned CAPTURE_DEPTH_DEF = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL_BASE     = 2'd0,
    CFG_SLOW_INTERVAL  = 2'd1,
    CFG_LEVEL_INTERVAL = 2'd2
  } cfg_reg_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_PLUG   = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_LOW    = 2'd2,
    STATUS_NORMAL = 2'd3
  } charge_status_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample0;
    logic [SAMPLE_W-1:0] sample1;
    logic [SAMPLE_W-1:0] sample2;
    logic [SAMPLE_W-1:0] sample3;
    logic [SAMPLE_W-1:0] sample4;
  } in_item_t;

  typedef struct packed {
    logic [PERCENT_W-1:0] battery_percent;
    logic [STATUS_W-1:0]  charge_status;
    logic                 indicator_request;
    logic [SAMPLE_W-1:0]  fast_average;
    logic [SAMPLE_W-1:0]  slow_average;
  } out_item_t;

  typedef struct packed {
    logic [BASE_W-1:0]     level_base;
    logic [SLOW_IV_W-1:0]  slow_interval;
    logic [LEVEL_IV_W-1:0] level_interval;
  } cfg_t;

  // Per-stage handshake: the stage's input is valid, and the pipeline moves.
  typedef struct packed {
    logic valid;
    logic advance;
  } pipe_ctl_t;

endpackage

>>> rtl/core/battery_level_and_charge_monitor_unit.sv
// Battery level and charge monitor.
// Input channel (in_valid_i/in_ready_o/in_data_i): one transfer carries a batch
// of five 10-bit ADC samples. Output channel (out_valid_o/out_ready_i/
// out_data_o): exactly one result per batch, in batch order.
// Configuration channel (cfg_valid_i/cfg_ready_o): cfg_index_i selects
// level_base (0), slow_interval (1) or level_interval (2); other indexes are
// ignored. cfg_ready_o is always high; write only while no batch is in flight.
// Throughput: one batch per cycle while the output is not stalled. A result is
// valid once its input transfer has passed the seven register stages, the
// first of which loads at the transfer edge: sample lanes, batch sum, batch
// mean, window running sums, window means, level multiply, and the output
// register that also holds the status logic.
// The whole pipeline advances together; while a result waits at the output
// with out_ready_i low, every stage holds and in_ready_o is low.
// Reset: configuration returns to 550 / 1000 / 60, the level reads 50 and the
// status normal; the windows are seeded by the first batch after reset, so no
// clearing pass is needed.
module battery_level_and_charge_monitor_unit #(
  parameter int unsigned BATCH_SIZE    = bmon_pkg::BATCH_SIZE_DEF,
  parameter int unsigned FAST_DEPTH    = bmon_pkg::FAST_DEPTH_DEF,
  parameter int unsigned SLOW_DEPTH    = bmon_pkg::SLOW_DEPTH_DEF,
  parameter int unsigned CAPTURE_DEPTH = bmon_pkg::CAPTURE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  bmon_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output bmon_pkg::out_item_t               out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bmon_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bmon_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned NumLanes = (BATCH_SIZE < bmon_pkg::SAMPLE_FIELDS) ?
                                     BATCH_SIZE : bmon_pkg::SAMPLE_FIELDS;
  localparam int unsigned SumW     = bmon_pkg::SAMPLE_W + $clog2(NumLanes);

  bmon_pkg::cfg_t      cfg_q;
  logic                advance;
  logic                lanes_valid_q;
  logic [bmon_pkg::SAMPLE_W-1:0] samples [bmon_pkg::SAMPLE_FIELDS];
  logic [SumW-1:0]     lane_out [NumLanes];
  logic                avg_valid, means_valid, level_fire;
  logic [bmon_pkg::SAMPLE_W-1:0] avg, fast_avg, slow_avg;
  bmon_pkg::pipe_ctl_t merge_ctl, window_ctl, status_ctl;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.level_base     <= bmon_pkg::BASE_W'(bmon_pkg::BASE_RESET);
      cfg_q.slow_interval  <= bmon_pkg::SLOW_IV_W'(bmon_pkg::SLOW_IV_RESET);
      cfg_q.level_interval <= bmon_pkg::LEVEL_IV_W'(bmon_pkg::LEVEL_IV_RESET);
    end else if (cfg_valid_i) begin
      case (bmon_pkg::cfg_reg_e'(cfg_index_i))
        bmon_pkg::CFG_LEVEL_BASE: begin
          cfg_q.level_base <= cfg_data_i[bmon_pkg::BASE_W-1:0];
        end
        bmon_pkg::CFG_SLOW_INTERVAL: begin
          cfg_q.slow_interval <= cfg_data_i[bmon_pkg::SLOW_IV_W-1:0];
        end
        bmon_pkg::CFG_LEVEL_INTERVAL: begin
          cfg_q.level_interval <= cfg_data_i[bmon_pkg::LEVEL_IV_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = advance;

  assign samples[0] = in_data_i.sample0;
  assign samples[1] = in_data_i.sample1;
  assign samples[2] = in_data_i.sample2;
  assign samples[3] = in_data_i.sample3;
  assign samples[4] = in_data_i.sample4;

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    bmon_lane #(
      .SumW(SumW)
    ) u_lane (
      .clk_i   (clk_i),
      .load_i  (advance),
      .sample_i(samples[g]),
      .sample_o(lane_out[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lanes_valid_q <= 1'b0;
    end else if (advance) begin
      lanes_valid_q <= in_valid_i;
    end
  end

  assign merge_ctl  = '{valid: lanes_valid_q, advance: advance};
  assign window_ctl = '{valid: avg_valid, advance: advance};
  assign status_ctl = '{valid: means_valid, advance: advance};

  bmon_merge #(
    .NumLanes (NumLanes),
    .BatchSize(BATCH_SIZE),
    .SumW     (SumW)
  ) u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (merge_ctl),
    .lanes_i(lane_out),
    .valid_o(avg_valid),
    .avg_o  (avg)
  );

  bmon_window #(
    .FastDepth(FAST_DEPTH),
    .SlowDepth(SLOW_DEPTH)
  ) u_window (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (window_ctl),
    .avg_i           (avg),
    .slow_interval_i (cfg_q.slow_interval),
    .level_interval_i(cfg_q.level_interval),
    .valid_o         (means_valid),
    .level_fire_o    (level_fire),
    .fast_avg_o      (fast_avg),
    .slow_avg_o      (slow_avg)
  );

  bmon_status #(
    .CaptureDepth(CAPTURE_DEPTH)
  ) u_status (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (status_ctl),
    .level_fire_i(level_fire),
    .fast_avg_i  (fast_avg),
    .slow_avg_i  (slow_avg),
    .level_base_i(cfg_q.level_base),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_data_o)
  );

endmodule

>>> rtl/core/bmon_ram.sv
module bmon_ram #(
  parameter int unsigned Width = 10,
  parameter int unsigned Depth = 20
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/bmon_lane.sv
module bmon_lane #(
  parameter int unsigned SumW = 13
) (
  input  logic                          clk_i,
  input  logic                          load_i,
  input  logic [bmon_pkg::SAMPLE_W-1:0] sample_i,
  output logic [SumW-1:0]               sample_o
);

  logic [bmon_pkg::SAMPLE_W-1:0] sample_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sample_q <= sample_i;
    end
  end

  // Samples are unsigned, so widening to the adder width is a zero extension.
  assign sample_o = SumW'(sample_q);

endmodule

>>> rtl/core/bmon_merge.sv
module bmon_merge #(
  parameter int unsigned NumLanes  = 5,
  parameter int unsigned BatchSize = 5,
  parameter int unsigned SumW      = 13
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bmon_pkg::pipe_ctl_t           ctl_i,
  input  logic [SumW-1:0]               lanes_i [NumLanes],
  output logic                          valid_o,
  output logic [bmon_pkg::SAMPLE_W-1:0] avg_o
);

  localparam longint unsigned Recip =
    ((64'd1 << bmon_pkg::DIV_SHIFT) + BatchSize - 1) / BatchSize;
  localparam int unsigned ProdW = SumW + bmon_pkg::RECIP_W;

  logic [SumW-1:0]               sum_d, sum_q;
  logic [ProdW-1:0]              prod;
  logic                          sum_valid_q, avg_valid_q;
  logic [bmon_pkg::SAMPLE_W-1:0] avg_q;

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NumLanes; i++) begin
      sum_d = sum_d + lanes_i[i];
    end
  end

  assign prod = ProdW'(sum_q) * ProdW'(Recip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
      avg_valid_q <= 1'b0;
    end else if (ctl_i.advance) begin
      sum_valid_q <= ctl_i.valid;
      avg_valid_q <= sum_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.advance) begin
      sum_q <= sum_d;
      avg_q <= prod[bmon_pkg::DIV_SHIFT +: bmon_pkg::SAMPLE_W];
    end
  end

  assign valid_o = avg_valid_q;
  assign avg_o   = avg_q;

endmodule

>>> rtl/core/bmon_window.sv
`include "battery_level_and_charge_monitor_unit_defines.svh"

module bmon_window #(
  parameter int unsigned FastDepth = 5,
  parameter int unsigned SlowDepth = 20
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bmon_pkg::pipe_ctl_t             ctl_i,
  input  logic [bmon_pkg::SAMPLE_W-1:0]   avg_i,
  input  logic [bmon_pkg::SLOW_IV_W-1:0]  slow_interval_i,
  input  logic [bmon_pkg::LEVEL_IV_W-1:0] level_interval_i,
  output logic                            valid_o,
  output logic                            level_fire_o,
  output logic [bmon_pkg::SAMPLE_W-1:0]   fast_avg_o,
  output logic [bmon_pkg::SAMPLE_W-1:0]   slow_avg_o
);

  localparam int unsigned SW       = bmon_pkg::SAMPLE_W;
  localparam int unsigned FastIdxW = $clog2(FastDepth);
  localparam int unsigned SlowIdxW = $clog2(SlowDepth);
  localparam int unsigned FastSumW = SW + $clog2(FastDepth);
  localparam int unsigned SlowSumW = SW + $clog2(SlowDepth);
  localparam int unsigned FastProdW = FastSumW + bmon_pkg::RECIP_W;
  localparam int unsigned SlowProdW = SlowSumW + bmon_pkg::RECIP_W;
  localparam longint unsigned FastRecip =
    ((64'd1 << bmon_pkg::DIV_SHIFT) + FastDepth - 1) / FastDepth;
  localparam longint unsigned SlowRecip =
    ((64'd1 << bmon_pkg::DIV_SHIFT) + SlowDepth - 1) / SlowDepth;

  logic                take;
  logic                started_q;
  logic [SW-1:0]       fast_win_q [FastDepth];
  logic [FastIdxW-1:0] fast_idx_q, fast_idx_d;
  logic [FastSumW-1:0] fast_sum_q, fast_sum_d, fast_base;
  logic [SW-1:0]       fast_evict;
  logic [SlowIdxW-1:0] slow_idx_q, slow_idx_d, slow_idx_nxt;
  logic                slow_wrapped_q, slow_wrapped_d;
  logic [SW-1:0]       slow_first_q, slow_first, slow_evict, slow_rdata;
  logic [SlowSumW-1:0] slow_sum_q, slow_sum_d, slow_base;
  logic [bmon_pkg::SLOW_IV_W-1:0]  dec_cnt_q, dec_cnt_d;
  logic [bmon_pkg::SLOW_IV_W:0]    dec_next;
  logic [bmon_pkg::LEVEL_IV_W-1:0] upd_cnt_q, upd_cnt_d;
  logic [bmon_pkg::LEVEL_IV_W:0]   upd_next;
  logic                slow_fire, slow_write, level_fire;
  logic                sums_valid_q, fire_q;
  logic                means_valid_q, means_fire_q;
  logic [FastProdW-1:0] fast_prod;
  logic [SlowProdW-1:0] slow_prod;
  logic [SW-1:0]        fast_avg_q, slow_avg_q;

  assign take = ctl_i.valid && ctl_i.advance;

  assign dec_next   = {1'b0, dec_cnt_q} + 1'b1;
  assign slow_fire  = dec_next >= {1'b0, slow_interval_i};
  assign dec_cnt_d  = slow_fire ? '0 : dec_next[bmon_pkg::SLOW_IV_W-1:0];
  assign upd_next   = {1'b0, upd_cnt_q} + 1'b1;
  assign level_fire = upd_next > {1'b0, level_interval_i};
  assign upd_cnt_d  = level_fire ? '0 : upd_next[bmon_pkg::LEVEL_IV_W-1:0];

  // Before the first batch both windows count as full of that batch's mean.
  assign fast_evict = started_q ? fast_win_q[fast_idx_q] : avg_i;
  assign fast_base  = started_q ? fast_sum_q : FastSumW'(avg_i) * FastSumW'(FastDepth);
  assign fast_sum_d = fast_base - FastSumW'(fast_evict) + FastSumW'(avg_i);
  assign fast_idx_d = (fast_idx_q == FastIdxW'(FastDepth - 1)) ? '0 : fast_idx_q + 1'b1;

  // The slow store is never cleared: until it has been written all the way
  // around, the entry being replaced still holds the first batch's mean.
  assign slow_first = started_q ? slow_first_q : avg_i;
  assign slow_evict = slow_wrapped_q ? slow_rdata : slow_first;
  assign slow_base  = started_q ? slow_sum_q : SlowSumW'(avg_i) * SlowSumW'(SlowDepth);
  assign slow_sum_d = slow_fire ? slow_base - SlowSumW'(slow_evict) + SlowSumW'(avg_i)
                                : slow_base;
  assign slow_write   = take && slow_fire;
  assign slow_idx_nxt = (slow_idx_q == SlowIdxW'(SlowDepth - 1)) ? '0 : slow_idx_q + 1'b1;
  assign slow_idx_d   = slow_write ? slow_idx_nxt : slow_idx_q;
  assign slow_wrapped_d = slow_wrapped_q ||
                          (slow_write && slow_idx_q == SlowIdxW'(SlowDepth - 1));

  bmon_ram #(
    .Width(SW),
    .Depth(SlowDepth)
  ) u_slow_ram (
    .clk_i  (clk_i),
    .we_i   (slow_write),
    .waddr_i(slow_idx_q),
    .wdata_i(avg_i),
    .raddr_i(slow_idx_d),
    .rdata_o(slow_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q      <= 1'b0;
      fast_idx_q     <= '0;
      slow_idx_q     <= '0;
      slow_wrapped_q <= 1'b0;
      dec_cnt_q      <= '0;
      upd_cnt_q      <= '0;
      sums_valid_q   <= 1'b0;
      fire_q         <= 1'b0;
      means_valid_q  <= 1'b0;
      means_fire_q   <= 1'b0;
    end else begin
      if (take) begin
        started_q      <= 1'b1;
        fast_idx_q     <= fast_idx_d;
        slow_idx_q     <= slow_idx_d;
        slow_wrapped_q <= slow_wrapped_d;
        dec_cnt_q      <= dec_cnt_d;
        upd_cnt_q      <= upd_cnt_d;
      end
      if (ctl_i.advance) begin
        sums_valid_q  <= ctl_i.valid;
        fire_q        <= level_fire;
        means_valid_q <= sums_valid_q;
        means_fire_q  <= fire_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      fast_sum_q   <= fast_sum_d;
      slow_sum_q   <= slow_sum_d;
      slow_first_q <= slow_first;
      for (int i = 0; i < FastDepth; i++) begin
        if (!started_q || fast_idx_q == FastIdxW'(i)) begin
          fast_win_q[i] <= avg_i;
        end
      end
    end
  end

  assign fast_prod = FastProdW'(fast_sum_q) * FastProdW'(FastRecip);
  assign slow_prod = SlowProdW'(slow_sum_q) * SlowProdW'(SlowRecip);

  always_ff @(posedge clk_i) begin
    if (ctl_i.advance) begin
      fast_avg_q <= fast_prod[bmon_pkg::DIV_SHIFT +: SW];
      slow_avg_q <= slow_prod[bmon_pkg::DIV_SHIFT +: SW];
    end
  end

  assign valid_o      = means_valid_q;
  assign level_fire_o = means_fire_q;
  assign fast_avg_o   = fast_avg_q;
  assign slow_avg_o   = slow_avg_q;

  `BMON_ASSERT_NEXT(a_started_sticky, started_q, started_q)
  `BMON_ASSERT_NEXT(a_wrap_sticky, slow_wrapped_q, slow_wrapped_q && started_q)
  `BMON_ASSERT_NEXT(a_slow_write_moves, slow_write, slow_idx_q != $past(slow_idx_q))

endmodule

>>> rtl/core/bmon_status.sv
`include "battery_level_and_charge_monitor_unit_defines.svh"

module bmon_status #(
  parameter int unsigned CaptureDepth = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bmon_pkg::pipe_ctl_t           ctl_i,
  input  logic                          level_fire_i,
  input  logic [bmon_pkg::SAMPLE_W-1:0] fast_avg_i,
  input  logic [bmon_pkg::SAMPLE_W-1:0] slow_avg_i,
  input  logic [bmon_pkg::BASE_W-1:0]   level_base_i,
  output logic                          out_valid_o,
  output bmon_pkg::out_item_t           out_item_o
);

  localparam int unsigned SW     = bmon_pkg::SAMPLE_W;
  localparam int unsigned PW     = bmon_pkg::PERCENT_W;
  localparam int unsigned LW     = bmon_pkg::LEVEL_RAW_W;
  localparam int unsigned JC     = bmon_pkg::JUDGE_COUNT;
  localparam int unsigned CntW   = $clog2(CaptureDepth);
  localparam int unsigned ProdW  = SW + bmon_pkg::RECIP_W;
  // d * 34 / 100 folded into one reciprocal multiply.
  localparam longint unsigned LevelRecip =
    ((64'd1 << bmon_pkg::DIV_SHIFT) * bmon_pkg::LEVEL_NUM + bmon_pkg::LEVEL_DEN - 1)
    / bmon_pkg::LEVEL_DEN;

  logic [SW-1:0]    span;
  logic [ProdW-1:0] level_prod;
  logic             lv_valid_q, lv_fire_q;
  logic [LW-1:0]    lv_q;
  logic [SW-1:0]    lv_fast_q, lv_slow_q;

  logic                     take;
  logic [PW-1:0]            level_q, level_d, lv_clamped;
  bmon_pkg::charge_status_e last_status_q, status_pre, status_fin;
  logic                     capturing_q, cap_start, cap_active, cap_end, plug;
  logic                     low_hit, indicator;
  logic [CntW-1:0]          cap_cnt_q;
  logic [CntW:0]            cnt_next;
  logic [SW-1:0]            store_q [JC];
  logic [SW-1:0]            judge_val [JC];
  logic [SW-1:0]            prev_fast_q;
  logic                     rise;
  logic                     out_valid_q;
  bmon_pkg::out_item_t      out_item_q;

  assign span       = (slow_avg_i > level_base_i) ? slow_avg_i - level_base_i : '0;
  assign level_prod = ProdW'(span) * ProdW'(LevelRecip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lv_valid_q <= 1'b0;
    end else if (ctl_i.advance) begin
      lv_valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.advance) begin
      lv_q      <= level_prod[bmon_pkg::DIV_SHIFT +: LW];
      lv_fire_q <= level_fire_i;
      lv_fast_q <= fast_avg_i;
      lv_slow_q <= slow_avg_i;
    end
  end

  assign take = lv_valid_q && ctl_i.advance;

  always_comb begin
    if (lv_q >= LW'(bmon_pkg::LEVEL_CAP_AT)) begin
      lv_clamped = PW'(bmon_pkg::LEVEL_FULL);
    end else if (lv_q == '0) begin
      lv_clamped = PW'(bmon_pkg::LEVEL_MIN);
    end else begin
      lv_clamped = lv_q[PW-1:0];
    end
  end

  assign level_d = lv_fire_q ? lv_clamped : level_q;
  // A previous mean of zero never counts as a rise.
  assign rise    = (prev_fast_q != '0) && (lv_fast_q > prev_fast_q);

  always_comb begin
    status_pre = last_status_q;
    low_hit    = 1'b0;
    cap_start  = 1'b0;
    if (rise && !capturing_q) begin
      cap_start = 1'b1;
    end else if (level_d == PW'(bmon_pkg::LEVEL_FULL)) begin
      status_pre = bmon_pkg::STATUS_FULL;
    end else if (level_d <= PW'(bmon_pkg::LEVEL_LOW_MAX)) begin
      status_pre = bmon_pkg::STATUS_LOW;
      low_hit    = 1'b1;
    end else begin
      status_pre = bmon_pkg::STATUS_NORMAL;
    end
  end

  assign cap_active = capturing_q || cap_start;
  assign cnt_next   = {1'b0, cap_cnt_q} + 1'b1;
  assign cap_end    = cap_active && (cnt_next >= (CntW + 1)'(CaptureDepth));

  // The judged values include the one captured by this very batch.
  always_comb begin
    for (int j = 0; j < JC; j++) begin
      judge_val[j] = (cap_active && cap_cnt_q == CntW'(j)) ? lv_fast_q : store_q[j];
    end
    plug = ({1'b0, judge_val[JC-1]} >=
            {1'b0, judge_val[0]} + (SW + 1)'(bmon_pkg::PLUG_MIN_RISE));
    for (int j = 1; j < JC; j++) begin
      if (judge_val[j] < judge_val[j-1]) begin
        plug = 1'b0;
      end
    end
  end

  assign status_fin = (cap_end && plug) ? bmon_pkg::STATUS_PLUG : status_pre;
  assign indicator  = low_hit || (cap_end && plug) || (status_fin != last_status_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q       <= PW'(bmon_pkg::LEVEL_RESET);
      last_status_q <= bmon_pkg::STATUS_NORMAL;
      capturing_q   <= 1'b0;
      cap_cnt_q     <= '0;
      prev_fast_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (take) begin
        level_q       <= level_d;
        last_status_q <= status_fin;
        prev_fast_q   <= lv_fast_q;
        if (cap_end) begin
          capturing_q <= 1'b0;
          cap_cnt_q   <= '0;
        end else if (cap_active) begin
          capturing_q <= 1'b1;
          cap_cnt_q   <= cnt_next[CntW-1:0];
        end
      end
      if (ctl_i.advance) begin
        out_valid_q <= lv_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      for (int j = 0; j < JC; j++) begin
        if (cap_active && cap_cnt_q == CntW'(j)) begin
          store_q[j] <= lv_fast_q;
        end
      end
      out_item_q.battery_percent   <= level_d;
      out_item_q.charge_status     <= status_fin;
      out_item_q.indicator_request <= indicator;
      out_item_q.fast_average      <= lv_fast_q;
      out_item_q.slow_average      <= lv_slow_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `BMON_ASSERT_IMPL(a_idle_count_zero, !capturing_q, cap_cnt_q == '0)
  `BMON_ASSERT_NEXT(a_change_flagged, take && (status_fin != last_status_q),
                    out_valid_q && out_item_q.indicator_request)
  `BMON_ASSERT_NEXT(a_end_stops_capture, take && cap_end, !capturing_q && cap_cnt_q == '0)

endmodule
